// ===== rtl/piecewise_line_time_map_macros.svh =====
// Assertion macros for the piecewise line/time map.
// Taken in by every RTL file that carries assertions; depends on nothing.
`ifndef PIECEWISE_LINE_TIME_MAP_MACROS_SVH
`define PIECEWISE_LINE_TIME_MAP_MACROS_SVH

// Same-cycle implication, held off during reset
`define PLTM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset
`define PLTM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pltm_pkg.sv =====
// Shared types and constants for the piecewise line/time map.
// Used by the divider and the top level; depends on nothing.
package pltm_pkg;

   // Field widths
   localparam int SLOT_W    = 4;
   localparam int SEG_DEPTH = 16;
   localparam int CNT_W     = 5;
   localparam int SLINE_W   = 21;
   localparam int TIME_W    = 64;
   localparam int RATE_W    = 32;
   localparam int QLINE_W   = 36;
   localparam int OFS_W     = 32;

   // Divider: |time difference| scaled by 2^24, two quotient bits a cycle
   localparam int FRAC_SHIFT = 24;
   localparam int DIV_DVD_W  = TIME_W + FRAC_SHIFT;
   localparam int DIV_STEPS  = DIV_DVD_W / 2;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   // Half a second in Q43.20, half a line in Q20.16
   localparam logic [TIME_W-1:0] HALF_T = 64'd524288;
   localparam logic [TIME_W-1:0] HALF_L = 64'd32768;

   localparam logic [QLINE_W-1:0] LINE_MAX = {QLINE_W{1'b1}};
   localparam logic [TIME_W-1:0]  TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
   localparam logic [TIME_W-1:0]  TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

   // Operation codes
   typedef enum logic [1:0] {
      OP_LOAD         = 2'd0,
      OP_TIME_TO_LINE = 2'd1,
      OP_LINE_TO_TIME = 2'd2,
      OP_RATE         = 2'd3
   } op_type;

   // Result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_MATCH  = 2'd1;
   localparam logic [1:0] STATUS_ZERO_RATE = 2'd2;

   // One segment table entry
   typedef struct packed {
      logic [SLINE_W-1:0]       start_line;
      logic signed [TIME_W-1:0] start_time;
      logic [RATE_W-1:0]        rate;
   } seg_type;

endpackage

// ===== rtl/piecewise_line_time_map.sv =====
// Piecewise line/time map: segment table in one synchronous RAM, search
// sequencer, radix-4 divider and a split multiplier.
// Depends on pltm_pkg, pltm_div and piecewise_line_time_map_macros.svh.
//
// A load beat writes one segment in the cycle it is taken and its result
// strobes on the next cycle. A query walks the table from the last loaded
// segment downwards, a RAM read then a compare per segment examined, 1 to 16
// segments in all. After the walk a rate query answers at once, a matched
// line-to-time query goes on through the 37x16 split multiplier and the
// saturating add, and a matched time-to-line query with a nonzero rate
// through the two-bit-per-cycle divider, then sign, add and clamp steps.
// Queries with no segments loaded answer on the next cycle.
// Each result is shown for one cycle on rsp_strobe and cannot be held off;
// busy falls in that same cycle, so the next start may be taken alongside it.
`include "piecewise_line_time_map_macros.svh"

module piecewise_line_time_map (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_op,
   input  logic [pltm_pkg::SLOT_W-1:0]         req_seg_slot,
   input  logic [pltm_pkg::SLINE_W-1:0]        req_seg_start_line,
   input  logic signed [pltm_pkg::TIME_W-1:0]  req_seg_start_time,
   input  logic [pltm_pkg::RATE_W-1:0]         req_seg_rate,
   input  logic                                req_seg_is_last,
   input  logic signed [pltm_pkg::TIME_W-1:0]  req_query_time,
   input  logic [pltm_pkg::QLINE_W-1:0]        req_query_line,
   input  logic signed [pltm_pkg::OFS_W-1:0]   req_time_offset,
   output logic                                rsp_strobe,
   output logic [1:0]                          rsp_status,
   output logic [pltm_pkg::QLINE_W-1:0]        rsp_line_out,
   output logic signed [pltm_pkg::TIME_W-1:0]  rsp_time_out,
   output logic [pltm_pkg::RATE_W-1:0]         rsp_rate_out
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_CMP,
      S_DIFF,
      S_DIV,
      S_NEG,
      S_ADD,
      S_CLAMP,
      S_LADJ,
      S_MULH,
      S_MULL,
      S_OFS,
      S_TSAT
   } state_type;

   state_type                         state_ff;
   logic                              accept;

   // Query beat and table state
   pltm_pkg::op_type                  op_ff;
   logic [pltm_pkg::TIME_W-1:0]       qtime_ff;
   logic [pltm_pkg::QLINE_W-1:0]      qline_ff;
   logic [pltm_pkg::OFS_W-1:0]        ofs_ff;
   logic [pltm_pkg::CNT_W-1:0]        count_ff;
   logic [pltm_pkg::SLOT_W-1:0]       idx_ff;

   pltm_pkg::seg_type                 seg_mem [pltm_pkg::SEG_DEPTH];
   pltm_pkg::seg_type                 rd_seg_ff;

   // Search compare
   logic signed [pltm_pkg::TIME_W:0]  time_thr;
   logic                              time_hit;
   logic signed [38:0]                line_thr;
   logic                              line_hit;
   logic                              hit;

   // Time-to-line datapath
   logic [pltm_pkg::TIME_W:0]         tdiff;
   logic [pltm_pkg::TIME_W-1:0]       mag;
   logic                              neg_ff;
   logic                              div_go;
   logic                              div_done;
   logic [pltm_pkg::DIV_DVD_W-1:0]    div_quo;
   logic [pltm_pkg::TIME_W-1:0]       quo_lo;
   logic [pltm_pkg::TIME_W-1:0]       quo_int;
   logic                              sat_in;
   logic [pltm_pkg::TIME_W-1:0]       qq_ff;
   logic                              sat_ff;
   logic [pltm_pkg::TIME_W-1:0]       line_ff;

   // Line-to-time datapath
   logic signed [38:0]                a_wide;
   logic [36:0]                       a_ff;
   logic [52:0]                       prod_hi;
   logic [52:0]                       prod_lo;
   logic [52:0]                       prod_ff;
   logic [68:0]                       prod_sum;
   logic [44:0]                       term_ff;
   logic [pltm_pkg::TIME_W-1:0]       add_ff;
   logic [pltm_pkg::TIME_W:0]         tsum;

   // Result registers
   logic                              rsp_strobe_ff;
   logic [1:0]                        rsp_status_ff;
   logic [pltm_pkg::QLINE_W-1:0]      rsp_line_ff;
   logic [pltm_pkg::TIME_W-1:0]       rsp_time_ff;
   logic [pltm_pkg::RATE_W-1:0]       rsp_rate_ff;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Segment RAM: one write port for loads, registered read at the walk index
   always_ff @(posedge clock) begin
      if (accept && (req_op == pltm_pkg::OP_LOAD)) begin
         seg_mem[req_seg_slot] <= '{start_line: req_seg_start_line,
                                    start_time: req_seg_start_time,
                                    rate:       req_seg_rate};
      end
      rd_seg_ff <= seg_mem[idx_ff];
   end

   // Segment match: start less half a unit is not after the query
   always_comb begin
      time_thr = $signed({rd_seg_ff.start_time[pltm_pkg::TIME_W-1], rd_seg_ff.start_time})
               - $signed({1'b0, pltm_pkg::HALF_T});
      time_hit = $signed({qtime_ff[pltm_pkg::TIME_W-1], qtime_ff}) >= time_thr;
      line_thr = $signed({2'b00, rd_seg_ff.start_line, 16'b0})
               - $signed({3'b000, pltm_pkg::HALF_L[35:0]});
      line_hit = $signed({3'b000, qline_ff}) >= line_thr;
      hit      = (op_ff == pltm_pkg::OP_TIME_TO_LINE) ? time_hit : line_hit;
   end

   // Time difference magnitude and sign, fed to the divider
   always_comb begin
      tdiff = {qtime_ff[pltm_pkg::TIME_W-1], qtime_ff}
            - {rd_seg_ff.start_time[pltm_pkg::TIME_W-1], rd_seg_ff.start_time};
      mag   = tdiff[pltm_pkg::TIME_W] ? (rd_seg_ff.start_time - qtime_ff)
                                      : (qtime_ff - rd_seg_ff.start_time);
   end

   assign div_go = (state_ff == S_DIFF);

   pltm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend ({mag, {pltm_pkg::FRAC_SHIFT{1'b0}}}),
      .divisor  (rd_seg_ff.rate),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Whole lines above 2^20 on the positive side saturate outright
   always_comb begin
      quo_lo  = div_quo[pltm_pkg::TIME_W-1:0];
      quo_int = div_quo[pltm_pkg::DIV_DVD_W-1:pltm_pkg::FRAC_SHIFT];
      sat_in  = !neg_ff && ((|quo_int[63:21]) || (quo_int[20] && (|quo_int[19:0])));
   end

   // Line offset from segment start plus half a line, and its split product
   always_comb begin
      a_wide   = $signed({3'b000, qline_ff}) - $signed({2'b00, rd_seg_ff.start_line, 16'b0})
               + $signed({3'b000, pltm_pkg::HALF_L[35:0]});
      prod_hi  = 53'(a_ff) * 53'(rd_seg_ff.rate[31:16]);
      prod_lo  = 53'(a_ff) * 53'(rd_seg_ff.rate[15:0]);
      prod_sum = {prod_ff, 16'b0} + {16'b0, prod_lo};
      tsum     = {rd_seg_ff.start_time[pltm_pkg::TIME_W-1], rd_seg_ff.start_time}
               + {add_ff[pltm_pkg::TIME_W-1], add_ff};
   end

   // Sequencer, datapath registers and result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff    <= pltm_pkg::op_type'(req_op);
                  qtime_ff <= req_query_time;
                  qline_ff <= req_query_line;
                  ofs_ff   <= req_time_offset;
                  if (req_op == pltm_pkg::OP_LOAD) begin
                     if (req_seg_is_last) begin
                        count_ff <= {1'b0, req_seg_slot} + 1'b1;
                     end
                     rsp_strobe_ff <= 1'b1;
                     rsp_status_ff <= pltm_pkg::STATUS_OK;
                     rsp_line_ff   <= '0;
                     rsp_time_ff   <= '0;
                     rsp_rate_ff   <= '0;
                  end else if (count_ff == '0) begin
                     rsp_strobe_ff <= 1'b1;
                     rsp_status_ff <= pltm_pkg::STATUS_NO_MATCH;
                     rsp_line_ff   <= '0;
                     rsp_time_ff   <= '0;
                     rsp_rate_ff   <= '0;
                  end else begin
                     idx_ff   <= pltm_pkg::SLOT_W'(count_ff - 1'b1);
                     state_ff <= S_READ;
                  end
               end
            end
            S_READ: begin
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (hit || (idx_ff == '0)) begin
                  case (op_ff)
                     pltm_pkg::OP_TIME_TO_LINE: begin
                        if (!hit || (rd_seg_ff.rate == '0)) begin
                           rsp_strobe_ff <= 1'b1;
                           rsp_status_ff <= hit ? pltm_pkg::STATUS_ZERO_RATE
                                                : pltm_pkg::STATUS_NO_MATCH;
                           rsp_line_ff   <= '0;
                           rsp_time_ff   <= '0;
                           rsp_rate_ff   <= '0;
                           state_ff      <= S_IDLE;
                        end else begin
                           state_ff <= S_DIFF;
                        end
                     end
                     pltm_pkg::OP_LINE_TO_TIME: begin
                        if (!hit) begin
                           rsp_strobe_ff <= 1'b1;
                           rsp_status_ff <= pltm_pkg::STATUS_NO_MATCH;
                           rsp_line_ff   <= '0;
                           rsp_time_ff   <= '0;
                           rsp_rate_ff   <= '0;
                           state_ff      <= S_IDLE;
                        end else begin
                           state_ff <= S_LADJ;
                        end
                     end
                     default: begin
                        // rate query: a miss falls back to segment 0, read last
                        rsp_strobe_ff <= 1'b1;
                        rsp_status_ff <= pltm_pkg::STATUS_OK;
                        rsp_line_ff   <= '0;
                        rsp_time_ff   <= '0;
                        rsp_rate_ff   <= rd_seg_ff.rate;
                        state_ff      <= S_IDLE;
                     end
                  endcase
               end else begin
                  idx_ff   <= idx_ff - 1'b1;
                  state_ff <= S_READ;
               end
            end
            S_DIFF: begin
               neg_ff   <= tdiff[pltm_pkg::TIME_W];
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_NEG;
               end
            end
            S_NEG: begin
               qq_ff    <= neg_ff ? (~quo_lo + 1'b1) : quo_lo;
               sat_ff   <= sat_in;
               state_ff <= S_ADD;
            end
            S_ADD: begin
               line_ff  <= qq_ff + {27'b0, rd_seg_ff.start_line, 16'b0} - pltm_pkg::HALF_L;
               state_ff <= S_CLAMP;
            end
            S_CLAMP: begin
               rsp_strobe_ff <= 1'b1;
               rsp_status_ff <= pltm_pkg::STATUS_OK;
               if (sat_ff || (!line_ff[63] && (|line_ff[62:36]))) begin
                  rsp_line_ff <= pltm_pkg::LINE_MAX;
               end else if (line_ff[63]) begin
                  rsp_line_ff <= '0;
               end else begin
                  rsp_line_ff <= line_ff[pltm_pkg::QLINE_W-1:0];
               end
               rsp_time_ff <= '0;
               rsp_rate_ff <= rd_seg_ff.rate;
               state_ff    <= S_IDLE;
            end
            S_LADJ: begin
               a_ff     <= a_wide[36:0];
               state_ff <= S_MULH;
            end
            S_MULH: begin
               prod_ff  <= prod_hi;
               state_ff <= S_MULL;
            end
            S_MULL: begin
               term_ff  <= prod_sum[68:24];
               state_ff <= S_OFS;
            end
            S_OFS: begin
               add_ff   <= {19'b0, term_ff} + {{32{ofs_ff[pltm_pkg::OFS_W-1]}}, ofs_ff};
               state_ff <= S_TSAT;
            end
            S_TSAT: begin
               rsp_strobe_ff <= 1'b1;
               rsp_status_ff <= pltm_pkg::STATUS_OK;
               rsp_line_ff   <= '0;
               if (tsum[pltm_pkg::TIME_W] != tsum[pltm_pkg::TIME_W-1]) begin
                  rsp_time_ff <= tsum[pltm_pkg::TIME_W] ? pltm_pkg::TIME_MIN
                                                        : pltm_pkg::TIME_MAX;
               end else begin
                  rsp_time_ff <= tsum[pltm_pkg::TIME_W-1:0];
               end
               rsp_rate_ff <= rd_seg_ff.rate;
               state_ff    <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_line_out = rsp_line_ff;
   assign rsp_time_out = rsp_time_ff;
   assign rsp_rate_out = rsp_rate_ff;

   // Checks
   `PLTM_ASSERT_IMPL(a_no_strobe_mid_item, clock, reset, busy, !rsp_strobe_ff, "result beat while an item is in flight")
   `PLTM_ASSERT_IMPL(a_div_done_waited, clock, reset, div_done, state_ff == S_DIV, "divider finished outside its wait state")
   `PLTM_ASSERT_NEXT(a_read_then_cmp, clock, reset, state_ff == S_READ, state_ff == S_CMP, "RAM read not followed by compare")
   `PLTM_ASSERT_NEXT(a_query_walks, clock, reset, accept && (req_op != pltm_pkg::OP_LOAD) && (count_ff != '0), state_ff == S_READ, "query with segments did not start the walk")
   `PLTM_ASSERT_IMPL(a_zero_rate_clean, clock, reset, rsp_strobe_ff && (rsp_status_ff == pltm_pkg::STATUS_ZERO_RATE), (rsp_line_ff == '0) && (rsp_rate_ff == '0), "zero-rate result carries data")

endmodule

// ===== rtl/pltm_div.sv =====
// Radix-4 restoring divider for the time-to-line mapping.
// Depends on pltm_pkg for the operand widths and step count.
module pltm_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           go,
   input  logic [pltm_pkg::DIV_DVD_W-1:0] dividend,
   input  logic [pltm_pkg::RATE_W-1:0]    divisor,
   output logic                           done,
   output logic [pltm_pkg::DIV_DVD_W-1:0] quotient
);

   logic                           run_ff;
   logic                           done_ff;
   logic [pltm_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [pltm_pkg::RATE_W-1:0]    rem_ff;
   logic [pltm_pkg::RATE_W-1:0]    rem_in;
   logic [pltm_pkg::RATE_W-1:0]    dvs_ff;
   logic [pltm_pkg::DIV_DVD_W-1:0] quo_ff;
   logic [pltm_pkg::DIV_DVD_W-1:0] quo_mid;
   logic [pltm_pkg::DIV_DVD_W-1:0] quo_in;
   logic [pltm_pkg::RATE_W:0]      step1;
   logic [pltm_pkg::RATE_W:0]      step2;

   // One restoring step: returns {quotient bit, new remainder}
   function automatic logic [pltm_pkg::RATE_W:0] div_step(
      input logic [pltm_pkg::RATE_W-1:0] rem,
      input logic                        din,
      input logic [pltm_pkg::RATE_W-1:0] dvs
   );
      logic [pltm_pkg::RATE_W:0] trial;
      logic [pltm_pkg::RATE_W:0] diff;
      trial = {rem, din};
      diff  = trial - {1'b0, dvs};
      if (trial >= {1'b0, dvs}) begin
         return {1'b1, diff[pltm_pkg::RATE_W-1:0]};
      end
      return {1'b0, trial[pltm_pkg::RATE_W-1:0]};
   endfunction

   // Two dependent steps per cycle; dividend bits shift out, quotient bits in
   always_comb begin
      step1   = div_step(rem_ff, quo_ff[pltm_pkg::DIV_DVD_W-1], dvs_ff);
      quo_mid = {quo_ff[pltm_pkg::DIV_DVD_W-2:0], step1[pltm_pkg::RATE_W]};
      step2   = div_step(step1[pltm_pkg::RATE_W-1:0], quo_mid[pltm_pkg::DIV_DVD_W-1], dvs_ff);
      rem_in  = step2[pltm_pkg::RATE_W-1:0];
      quo_in  = {quo_mid[pltm_pkg::DIV_DVD_W-2:0], step2[pltm_pkg::RATE_W]};
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= pltm_pkg::DIV_CNT_W'(pltm_pkg::DIV_STEPS);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == pltm_pkg::DIV_CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (go) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== test/piecewise_line_time_map_tb.sv =====
// Self-checking bench for the piecewise line/time map: loads segment tables,
// runs time, line and rate queries, and checks every result beat against an
// in-bench prediction. Depends on pltm_pkg and piecewise_line_time_map only.
`timescale 1ns / 100ps

module piecewise_line_time_map_tb;

   localparam int RUN_ITEMS    = 775;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 100;

   localparam logic signed [pltm_pkg::TIME_W-1:0] I64_MIN   = $signed(pltm_pkg::TIME_MIN);
   localparam logic signed [pltm_pkg::TIME_W-1:0] I64_MAX   = $signed(pltm_pkg::TIME_MAX);
   localparam logic signed [pltm_pkg::TIME_W-1:0] HALF_SEC  = $signed(pltm_pkg::HALF_T);
   localparam logic signed [pltm_pkg::TIME_W-1:0] HALF_LINE = $signed(pltm_pkg::HALF_L);
   localparam logic signed [pltm_pkg::TIME_W-1:0] TIME_EDGE = I64_MIN + HALF_SEC;

   typedef struct packed {
      pltm_pkg::op_type                   op;
      logic [pltm_pkg::SLOT_W-1:0]        slot;
      logic [pltm_pkg::SLINE_W-1:0]       sline;
      logic signed [pltm_pkg::TIME_W-1:0] stime;
      logic [pltm_pkg::RATE_W-1:0]        rate;
      logic                               last;
      logic signed [pltm_pkg::TIME_W-1:0] qtime;
      logic [pltm_pkg::QLINE_W-1:0]       qline;
      logic signed [pltm_pkg::OFS_W-1:0]  ofs;
   } map_cmd_type;

   typedef struct packed {
      logic [1:0]                         status;
      logic [pltm_pkg::QLINE_W-1:0]       line;
      logic signed [pltm_pkg::TIME_W-1:0] tval;
      logic [pltm_pkg::RATE_W-1:0]        rate;
   } map_answer_type;

   logic clock;
   logic reset;
   logic start = 1'b0;
   logic busy;
   logic [1:0]                           req_op = '0;
   logic [pltm_pkg::SLOT_W-1:0]          req_seg_slot = '0;
   logic [pltm_pkg::SLINE_W-1:0]         req_seg_start_line = '0;
   logic signed [pltm_pkg::TIME_W-1:0]   req_seg_start_time = '0;
   logic [pltm_pkg::RATE_W-1:0]          req_seg_rate = '0;
   logic                                 req_seg_is_last = 1'b0;
   logic signed [pltm_pkg::TIME_W-1:0]   req_query_time = '0;
   logic [pltm_pkg::QLINE_W-1:0]         req_query_line = '0;
   logic signed [pltm_pkg::OFS_W-1:0]    req_time_offset = '0;
   logic                                 rsp_strobe;
   logic [1:0]                           rsp_status;
   logic [pltm_pkg::QLINE_W-1:0]         rsp_line_out;
   logic signed [pltm_pkg::TIME_W-1:0]   rsp_time_out;
   logic [pltm_pkg::RATE_W-1:0]          rsp_rate_out;

   // Pending command beats and the answers still owed by the block
   map_cmd_type    pending_cmds[$];
   map_answer_type awaited_answers[$];

   // Segment table as the block should hold it, updated at acceptance
   logic [pltm_pkg::SLINE_W-1:0]       tbl_line [pltm_pkg::SEG_DEPTH];
   logic signed [pltm_pkg::TIME_W-1:0] tbl_time [pltm_pkg::SEG_DEPTH];
   logic [pltm_pkg::RATE_W-1:0]        tbl_rate [pltm_pkg::SEG_DEPTH];
   int                                 tbl_count = 0;

   // Table as the stimulus generator has built it so far
   logic [pltm_pkg::SLINE_W-1:0]       gen_line [pltm_pkg::SEG_DEPTH];
   logic signed [pltm_pkg::TIME_W-1:0] gen_time [pltm_pkg::SEG_DEPTH];
   logic [pltm_pkg::RATE_W-1:0]        gen_rate [pltm_pkg::SEG_DEPTH];
   bit                                 gen_written [pltm_pkg::SEG_DEPTH];
   int                                 gen_count = 0;

   map_cmd_type drv_cmd;
   logic        beat_taken = 1'b0;
   int          gap_left = 0;
   int          burst_left = 0;
   int          idle_cycles = 0;
   int          mismatches = 0;

   piecewise_line_time_map dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_seg_slot       (req_seg_slot),
      .req_seg_start_line (req_seg_start_line),
      .req_seg_start_time (req_seg_start_time),
      .req_seg_rate       (req_seg_rate),
      .req_seg_is_last    (req_seg_is_last),
      .req_query_time     (req_query_time),
      .req_query_line     (req_query_line),
      .req_time_offset    (req_time_offset),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_line_out       (rsp_line_out),
      .rsp_time_out       (rsp_time_out),
      .rsp_rate_out       (rsp_rate_out)
   );

   // Map one accepted command to its answer, updating the table on loads
   function automatic map_answer_type compute_map_answer(map_cmd_type c);
      map_answer_type                     ans;
      int                                 i;
      logic signed [pltm_pkg::TIME_W-1:0] s, q, add, qs;
      logic signed [pltm_pkg::OFS_W-1:0]  ofs_s;
      logic signed [pltm_pkg::TIME_W:0]   sum;
      logic [63:0]                        r, mag, quo, rem, qq, ln, a, x, y, term;
      logic                               neg;
      ans = '0;
      case (c.op)
         pltm_pkg::OP_LOAD: begin
            tbl_line[c.slot] = c.sline;
            tbl_time[c.slot] = c.stime;
            tbl_rate[c.slot] = c.rate;
            if (c.last)
               tbl_count = int'(c.slot) + 1;
         end
         pltm_pkg::OP_TIME_TO_LINE: begin
            q = c.qtime;
            i = tbl_count - 1;
            // a start within half a second of the minimum is never after the query
            while (i >= 0 && tbl_time[i] >= TIME_EDGE && q < tbl_time[i] - HALF_SEC)
               i--;
            if (i < 0) begin
               ans.status = pltm_pkg::STATUS_NO_MATCH;
            end else if (tbl_rate[i] == '0) begin
               ans.status = pltm_pkg::STATUS_ZERO_RATE;
            end else begin
               s = tbl_time[i];
               r = {32'd0, tbl_rate[i]};
               neg = q < s;
               if (neg)
                  mag = s - q;
               else
                  mag = q - s;
               quo = mag / r;
               rem = mag % r;
               if (!neg && quo > 64'd1048576) begin
                  ln = {28'd0, pltm_pkg::LINE_MAX};
               end else begin
                  // 64-bit wrap on the scaled quotient, as the datapath does
                  qq = (quo << 24) + ((rem << 24) / r);
                  if (neg)
                     qq = -qq;
                  ln = qq + {27'd0, tbl_line[i], 16'd0} - pltm_pkg::HALF_L;
                  if ($signed(ln) < 0)
                     ln = '0;
                  else if ($signed(ln) > $signed({28'd0, pltm_pkg::LINE_MAX}))
                     ln = {28'd0, pltm_pkg::LINE_MAX};
               end
               ans.line = ln[pltm_pkg::QLINE_W-1:0];
               ans.rate = tbl_rate[i];
            end
         end
         default: begin
            qs = $signed({28'd0, c.qline});
            i = tbl_count - 1;
            while (i >= 0 && qs < $signed({27'd0, tbl_line[i], 16'd0}) - HALF_LINE)
               i--;
            if (c.op == pltm_pkg::OP_RATE) begin
               // no match falls back to segment 0 unless the table is empty
               if (tbl_count == 0)
                  ans.status = pltm_pkg::STATUS_NO_MATCH;
               else
                  ans.rate = tbl_rate[(i < 0) ? 0 : i];
            end else if (i < 0) begin
               ans.status = pltm_pkg::STATUS_NO_MATCH;
            end else begin
               a = {28'd0, c.qline} - {27'd0, tbl_line[i], 16'd0} + pltm_pkg::HALF_L;
               x = a * {48'd0, tbl_rate[i][31:16]};
               y = a * {48'd0, tbl_rate[i][15:0]};
               term = (x >> 8) + ((((x & 64'hFF) << 16) + y) >> 24);
               ofs_s = c.ofs;
               add = $signed(term) + ofs_s;
               s = tbl_time[i];
               sum = $signed({s[pltm_pkg::TIME_W-1], s})
                   + $signed({add[pltm_pkg::TIME_W-1], add});
               if (sum > $signed({1'b0, pltm_pkg::TIME_MAX}))
                  ans.tval = I64_MAX;
               else if (sum < $signed({1'b1, pltm_pkg::TIME_MIN}))
                  ans.tval = I64_MIN;
               else
                  ans.tval = sum[pltm_pkg::TIME_W-1:0];
               ans.rate = tbl_rate[i];
            end
         end
      endcase
      return ans;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Rates: mostly scan-like, some zero, tiny or anything at all
   function automatic logic [pltm_pkg::RATE_W-1:0] pick_rate();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return $urandom_range(1, 255);
         2:       return $urandom;
         default: return $urandom_range(1 << 18, 1 << 26);
      endcase
   endfunction

   task automatic queue_load(input int slot, input logic [pltm_pkg::SLINE_W-1:0] sl,
                             input logic signed [pltm_pkg::TIME_W-1:0] st,
                             input logic [pltm_pkg::RATE_W-1:0] rt, input bit last);
      map_cmd_type c;
      c.op    = pltm_pkg::OP_LOAD;
      c.slot  = pltm_pkg::SLOT_W'(slot);
      c.sline = sl;
      c.stime = st;
      c.rate  = rt;
      c.last  = last;
      c.qtime = rand64();
      c.qline = pltm_pkg::QLINE_W'(rand64());
      c.ofs   = $urandom;
      pending_cmds.push_back(c);
      gen_line[slot]    = sl;
      gen_time[slot]    = st;
      gen_rate[slot]    = rt;
      gen_written[slot] = 1'b1;
      if (last)
         gen_count = slot + 1;
   endtask

   task automatic queue_query(input pltm_pkg::op_type op,
                              input logic signed [pltm_pkg::TIME_W-1:0] qt,
                              input logic [pltm_pkg::QLINE_W-1:0] ql,
                              input logic signed [pltm_pkg::OFS_W-1:0] ofs);
      map_cmd_type c;
      c.op    = op;
      c.slot  = pltm_pkg::SLOT_W'($urandom);
      c.sline = pltm_pkg::SLINE_W'($urandom_range(0, 1048576));
      c.stime = rand64();
      c.rate  = $urandom;
      c.last  = 1'($urandom);
      c.qtime = qt;
      c.qline = ql;
      c.ofs   = ofs;
      pending_cmds.push_back(c);
   endtask

   // Query aimed at one segment of the current table: edges, interior, noise
   task automatic queue_aimed_query();
      int                                 j;
      logic signed [pltm_pkg::TIME_W-1:0] bt, qt;
      logic [63:0]                        bl, ql, lq;
      logic signed [pltm_pkg::OFS_W-1:0]  ofs;
      j  = $urandom_range(0, gen_count - 1);
      bt = gen_time[j];
      bl = {27'd0, gen_line[j], 16'd0};
      lq = 64'(($urandom_range(0, 3000) << 16) | $urandom_range(0, 65535));
      case ($urandom_range(0, 7))
         0: begin
            qt = bt - HALF_SEC;
            ql = bl - pltm_pkg::HALF_L;
         end
         1: begin
            qt = bt - HALF_SEC - 1;
            ql = bl - pltm_pkg::HALF_L - 1;
         end
         2: begin
            qt = bt;
            ql = bl;
         end
         6: begin
            qt = bt + ($signed(rand64()) >>> 39);
            ql = bl + $urandom_range(0, 65535) - 64'd32768;
         end
         7: begin
            qt = rand64();
            ql = rand64();
         end
         default: begin
            qt = bt + $signed((lq * gen_rate[j]) >> 24);
            ql = bl + lq;
         end
      endcase
      if ($urandom_range(0, 3) == 0)
         ofs = $urandom;
      else
         ofs = $urandom_range(0, 1 << 21) - (1 << 20);
      queue_query(pltm_pkg::op_type'($urandom_range(1, 3)), qt,
                  ql[pltm_pkg::QLINE_W-1:0], ofs);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
   end

   // Stimulus: directed corner beats, then random tables and queries
   initial begin
      int                                 n, first, m, kind, g, s, k;
      bit                                 ok;
      logic [pltm_pkg::SLINE_W-1:0]       ln;
      logic signed [pltm_pkg::TIME_W-1:0] tm;
      logic [63:0]                        step;
      logic [pltm_pkg::SLINE_W-1:0]       b_line [pltm_pkg::SEG_DEPTH];
      logic signed [pltm_pkg::TIME_W-1:0] b_time [pltm_pkg::SEG_DEPTH];
      logic [pltm_pkg::RATE_W-1:0]        b_rate [pltm_pkg::SEG_DEPTH];

      // empty table
      queue_query(pltm_pkg::OP_TIME_TO_LINE, I64_MIN, '0, '0);
      queue_query(pltm_pkg::OP_LINE_TO_TIME, '0, pltm_pkg::LINE_MAX, '0);
      queue_query(pltm_pkg::OP_RATE, '0, '0, '0);
      // segment at the bottom of time with zero rate
      queue_load(0, '0, I64_MIN, '0, 1'b1);
      queue_query(pltm_pkg::OP_TIME_TO_LINE, I64_MIN, '0, '0);
      queue_query(pltm_pkg::OP_LINE_TO_TIME, '0, '0, 32'sh8000_0000);
      queue_query(pltm_pkg::OP_RATE, '0, pltm_pkg::LINE_MAX, '0);
      queue_load(1, 21'h100000, '0, 32'hFFFF_FFFF, 1'b0);
      queue_load(2, 21'd100, I64_MAX, 32'd1, 1'b1);
      queue_query(pltm_pkg::OP_TIME_TO_LINE, I64_MAX, '0, '0);
      queue_query(pltm_pkg::OP_TIME_TO_LINE, I64_MAX - HALF_SEC - 1, '0, '0);
      queue_query(pltm_pkg::OP_TIME_TO_LINE, -HALF_SEC, '0, '0);
      queue_query(pltm_pkg::OP_TIME_TO_LINE, -HALF_SEC - 1, '0, '0);
      queue_query(pltm_pkg::OP_LINE_TO_TIME, '0, pltm_pkg::LINE_MAX, 32'sh7FFF_FFFF);
      queue_query(pltm_pkg::OP_LINE_TO_TIME, '0, (36'd100 << 16) - 36'd32768, -32'sd1);
      queue_query(pltm_pkg::OP_RATE, '0, '0, '0);
      // segment 0 moved past line 0: rate falls back, line query misses
      queue_load(0, 21'd50, -64'sd1000, 32'd1, 1'b0);
      queue_query(pltm_pkg::OP_RATE, '0, '0, '0);
      queue_query(pltm_pkg::OP_TIME_TO_LINE, -64'sd1000 - HALF_SEC, '0, '0);
      queue_query(pltm_pkg::OP_LINE_TO_TIME, '0, '0, '0);
      // an ordinary scan segment
      queue_load(3, 21'd500, 64'sh0000_0100_0000_0000, 32'd268435, 1'b1);
      queue_query(pltm_pkg::OP_TIME_TO_LINE, 64'sh0000_0100_0010_0000, '0, '0);
      queue_query(pltm_pkg::OP_LINE_TO_TIME, '0, {20'd1500, 16'h8000}, 32'sd12345);

      while (pending_cmds.size() < RUN_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind <= 2) begin
            // fresh table of increasing lines and times, last slot closes it
            n  = $urandom_range(1, pltm_pkg::SEG_DEPTH);
            ln = pltm_pkg::SLINE_W'($urandom_range(0, 4000));
            tm = $signed(rand64()) >>> $urandom_range(2, 40);
            for (k = 0; k < n; k++) begin
               b_line[k] = ln;
               b_time[k] = tm;
               b_rate[k] = pick_rate();
               g = $urandom_range(0, 3000);
               if ($urandom_range(0, 7) == 0)
                  ln = pltm_pkg::SLINE_W'($urandom_range(ln, 1048576));
               else
                  ln = (ln + g > 1048576) ? 21'h100000 : pltm_pkg::SLINE_W'(ln + g);
               if (b_rate[k] == '0) begin
                  tm = tm + $urandom_range(0, 1 << 30);
               end else begin
                  step = 64'(g);
                  step = ((step << 16) * b_rate[k]) >> 24;
                  tm = tm + $signed(step) + $urandom_range(0, 1 << 12);
               end
            end
            first = $urandom_range(0, n - 1);
            for (k = 0; k < n - 1; k++) begin
               s = (first + k) % (n - 1);
               queue_load(s, b_line[s], b_time[s], b_rate[s], 1'b0);
            end
            queue_load(n - 1, b_line[n-1], b_time[n-1], b_rate[n-1], 1'b1);
            m = $urandom_range(4, 20);
            repeat (m) queue_aimed_query();
         end else if (kind <= 7 && gen_count > 0) begin
            queue_aimed_query();
         end else if (kind == 8) begin
            // stray load; it may only close the table over written slots
            s  = $urandom_range(0, pltm_pkg::SEG_DEPTH - 1);
            ok = 1'b1;
            for (k = 0; k < s; k++)
               if (!gen_written[k])
                  ok = 1'b0;
            queue_load(s, pltm_pkg::SLINE_W'($urandom_range(0, 1048576)), rand64(),
                       pick_rate(), ok && ($urandom_range(0, 1) == 1));
         end else begin
            queue_query(pltm_pkg::op_type'($urandom_range(1, 3)), rand64(),
                        pltm_pkg::QLINE_W'(rand64()), $urandom);
         end
      end

      while (pending_cmds.size() != 0 || start || awaited_answers.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      // every accepted beat must have had its result by now
      if (awaited_answers.size() != 0) begin
         $display("%0t: result beats expected %0d actual 0", $time,
                  awaited_answers.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("piecewise_line_time_map_tb OK");
      else
         $display("piecewise_line_time_map_tb NOT OK");
      $finish;
   end

   // Driver: bursts of beats with random gaps, held until taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         if (gap_left > 0 || pending_cmds.size() == 0) begin
            start <= 1'b0;
            if (gap_left > 0)
               gap_left--;
         end else begin
            drv_cmd = pending_cmds.pop_front();
            req_op             <= drv_cmd.op;
            req_seg_slot       <= drv_cmd.slot;
            req_seg_start_line <= drv_cmd.sline;
            req_seg_start_time <= drv_cmd.stime;
            req_seg_rate       <= drv_cmd.rate;
            req_seg_is_last    <= drv_cmd.last;
            req_query_time     <= drv_cmd.qtime;
            req_query_line     <= drv_cmd.qline;
            req_time_offset    <= drv_cmd.ofs;
            start              <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               case ($urandom_range(0, 5))
                  0, 1, 2: gap_left = $urandom_range(0, 3);
                  3, 4:    gap_left = $urandom_range(4, 30);
                  default: gap_left = $urandom_range(31, 90);
               endcase
            end
         end
      end
   end

   // Acceptance: predict each taken beat; watchdog on stalled progress
   always @(posedge clock) begin
      if (reset) begin
         beat_taken  <= 1'b0;
         idle_cycles <= 0;
      end else begin
         beat_taken <= start && !busy;
         if (start && !busy)
            awaited_answers.push_back(compute_map_answer(drv_cmd));
         if ((start && !busy) || rsp_strobe) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("piecewise_line_time_map_tb NOT OK");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Monitor: each result beat against the oldest awaited answer
   always @(posedge clock) begin
      map_answer_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_answers.size() == 0) begin
            $display("%0t: result beat with nothing awaited, status %0d", $time, rsp_status);
            mismatches++;
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               mismatches++;
            end
            if (rsp_line_out !== want.line) begin
               $display("%0t: line_out expected %h actual %h", $time, want.line, rsp_line_out);
               mismatches++;
            end
            if (rsp_time_out !== want.tval) begin
               $display("%0t: time_out expected %h actual %h", $time, want.tval, rsp_time_out);
               mismatches++;
            end
            if (rsp_rate_out !== want.rate) begin
               $display("%0t: rate_out expected %h actual %h", $time, want.rate, rsp_rate_out);
               mismatches++;
            end
         end
      end
   end

endmodule

// ===== piecewise_line_time_map.f =====
+incdir+rtl
rtl/pltm_pkg.sv
rtl/pltm_div.sv
rtl/piecewise_line_time_map.sv
test/piecewise_line_time_map_tb.sv
